// ----- rtl/smart_card_atr_parser_macros.svh -----
// Assertion macros shared by the ATR parser checker.
`ifndef SMART_CARD_ATR_PARSER_MACROS_SVH
`define SMART_CARD_ATR_PARSER_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define SCAP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ATR parser check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define SCAP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ATR parser check failed");

`endif

// ----- rtl/scap_pkg.sv -----
// Package with constants, status codes and TA1 lookup tables of the ATR parser.
`timescale 1ns / 1ps
`default_nettype none

package scap_pkg;

  // Default limit on ATR length in bytes
  localparam int unsigned MaxAtrBytesDefault = 33;

  // Sync byte values
  localparam logic [7:0] SyncDirect  = 8'h3B;
  localparam logic [7:0] SyncInverse = 8'h3F;

  // Result status codes
  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusEmpty   = 2'd1;
  localparam logic [1:0] StatusBadSync = 2'd2;

  // Internal error codes
  localparam logic [1:0] ErrNone    = 2'd0;
  localparam logic [1:0] ErrBadSync = 2'd2;

  // Clock rate conversion factor Fi; -1 for reserved codes
  function automatic logic signed [12:0] fi_lookup(input logic [3:0] code);
    logic signed [12:0] val;
    unique case (code)
      4'd0:    val = 13'sd372;
      4'd1:    val = 13'sd372;
      4'd2:    val = 13'sd558;
      4'd3:    val = 13'sd744;
      4'd4:    val = 13'sd1116;
      4'd5:    val = 13'sd1488;
      4'd6:    val = 13'sd1860;
      4'd9:    val = 13'sd512;
      4'd10:   val = 13'sd768;
      4'd11:   val = 13'sd1024;
      4'd12:   val = 13'sd1536;
      4'd13:   val = 13'sd2048;
      default: val = -13'sd1;
    endcase
    return val;
  endfunction

  // Maximum clock in 100 kHz units; -1 for reserved codes
  function automatic logic signed [8:0] f_lookup(input logic [3:0] code);
    logic signed [8:0] val;
    unique case (code)
      4'd0:    val = 9'sd40;
      4'd1:    val = 9'sd50;
      4'd2:    val = 9'sd60;
      4'd3:    val = 9'sd80;
      4'd4:    val = 9'sd120;
      4'd5:    val = 9'sd160;
      4'd6:    val = 9'sd200;
      4'd9:    val = 9'sd50;
      4'd10:   val = 9'sd75;
      4'd11:   val = 9'sd100;
      4'd12:   val = 9'sd150;
      4'd13:   val = 9'sd200;
      default: val = -9'sd1;
    endcase
    return val;
  endfunction

  // Baud rate adjustment factor Di; -1 for reserved codes
  function automatic logic signed [6:0] di_lookup(input logic [3:0] code);
    logic signed [6:0] val;
    unique case (code)
      4'd1:    val = 7'sd1;
      4'd2:    val = 7'sd2;
      4'd3:    val = 7'sd4;
      4'd4:    val = 7'sd8;
      4'd5:    val = 7'sd16;
      4'd6:    val = 7'sd32;
      4'd8:    val = 7'sd12;
      4'd9:    val = 7'sd20;
      default: val = -7'sd1;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/smart_card_atr_parser.sv -----
// Top level of the ISO 7816-3 Answer-To-Reset parser.
// Feed the ATR one byte per transaction, starting at the sync byte, and flag the final
// transaction with last_byte_i; an empty ATR is a single transaction with byte_present_i low
// and last_byte_i high. Every byte is parsed in the cycle it is accepted, so one transaction
// is taken each clock. The summary of the ATR (status, TA1 codes with their table values,
// TC1 guard time, historical byte offset and count) appears in the result register on the
// cycle after the final transaction and is held until taken. The input stalls only while a
// result waits and the output side stalls. The parser returns to its reset state after each
// final transaction, ready for the next ATR. Bytes beyond MAX_ATR_BYTES are dropped.
`timescale 1ns / 1ps
`default_nettype none

module smart_card_atr_parser #(
  parameter int unsigned MAX_ATR_BYTES = scap_pkg::MaxAtrBytesDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         atr_byte_i,
  input  wire logic               byte_present_i,
  input  wire logic               last_byte_i,
  // result channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [1:0]              status_o,
  output logic                    ta1_present_o,
  output logic [3:0]              fi_index_o,
  output logic [3:0]              di_index_o,
  output logic signed [12:0]      rate_factor_o,
  output logic signed [8:0]       max_clock_o,
  output logic signed [6:0]       baud_divisor_o,
  output logic signed [8:0]       extra_guard_o,
  output logic [3:0]              hist_count_o,
  output logic [5:0]              hist_offset_o
);

  localparam logic [5:0] MaxBytes = 6'(MAX_ATR_BYTES);

  typedef enum logic [1:0] {
    PhSync,
    PhT0,
    PhIface,
    PhTail
  } phase_e;

  // Parser state
  phase_e     phase_q, phase_d;
  logic [3:0] mask_q, mask_d;
  logic       first_q, first_d;
  logic [5:0] pos_q, pos_d;
  logic [3:0] decl_q, decl_d;
  logic       ta1_here_q, ta1_here_d;
  logic [7:0] ta1_q, ta1_d;
  logic       tc1_here_q, tc1_here_d;
  logic [7:0] tc1_q, tc1_d;
  logic [1:0] err_q, err_d;
  logic [5:0] hstart_q, hstart_d;

  // Result register
  logic                  out_valid_q;
  logic [1:0]            status_q, status_d;
  logic                  ta1p_q, ta1p_d;
  logic [3:0]            fi_q, fi_d;
  logic [3:0]            di_q, di_d;
  logic signed [12:0]    rate_q, rate_d;
  logic signed [8:0]     fmax_q, fmax_d;
  logic signed [6:0]     baud_q, baud_d;
  logic signed [8:0]     guard_q, guard_d;
  logic [3:0]            hcnt_q, hcnt_d;
  logic [5:0]            hoff_q, hoff_d;

  logic       take;
  logic       ok;
  logic [1:0] sel;
  logic [5:0] remaining;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign take       = in_valid_i & ~in_stall_o;

  // Advance the parser by one byte
  always_comb begin
    phase_d    = phase_q;
    mask_d     = mask_q;
    first_d    = first_q;
    pos_d      = pos_q;
    decl_d     = decl_q;
    ta1_here_d = ta1_here_q;
    ta1_d      = ta1_q;
    tc1_here_d = tc1_here_q;
    tc1_d      = tc1_q;
    err_d      = err_q;
    hstart_d   = hstart_q;
    sel        = 2'd3;

    priority if (mask_q[0]) begin
      sel = 2'd0;
    end else if (mask_q[1]) begin
      sel = 2'd1;
    end else if (mask_q[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end

    if (take && byte_present_i && (pos_q < MaxBytes)) begin
      if (err_q == scap_pkg::ErrNone) begin
        unique case (phase_q)
          PhSync: begin
            if (atr_byte_i != scap_pkg::SyncDirect && atr_byte_i != scap_pkg::SyncInverse) begin
              err_d = scap_pkg::ErrBadSync;
            end
            phase_d = PhT0;
          end
          PhT0: begin
            decl_d  = atr_byte_i[3:0];
            mask_d  = atr_byte_i[7:4];
            first_d = 1'b1;
            if (atr_byte_i[7:4] == 4'd0) begin
              phase_d  = PhTail;
              hstart_d = pos_q + 6'd1;
            end else begin
              phase_d = PhIface;
            end
          end
          PhIface: begin
            mask_d = mask_q & ~(4'd1 << sel);
            if (first_q && sel == 2'd0) begin
              ta1_here_d = 1'b1;
              ta1_d      = atr_byte_i;
            end
            if (first_q && sel == 2'd2) begin
              tc1_here_d = 1'b1;
              tc1_d      = atr_byte_i;
            end
            if (sel == 2'd3) begin
              mask_d  = atr_byte_i[7:4];
              first_d = 1'b0;
            end
            if (mask_d == 4'd0) begin
              phase_d  = PhTail;
              hstart_d = pos_q + 6'd1;
            end
          end
          PhTail: begin
          end
          default: begin
          end
        endcase
      end
      pos_d = pos_q + 6'd1;
    end
  end

  // Build the summary from the updated state
  always_comb begin
    priority if (pos_d == 6'd0) begin
      status_d = scap_pkg::StatusEmpty;
    end else if (err_d != scap_pkg::ErrNone) begin
      status_d = scap_pkg::StatusBadSync;
    end else begin
      status_d = scap_pkg::StatusOk;
    end
    ok        = (status_d == scap_pkg::StatusOk);
    ta1p_d    = ok & ta1_here_d;
    fi_d      = ta1p_d ? ta1_d[7:4] : 4'd0;
    di_d      = ta1p_d ? ta1_d[3:0] : 4'd0;
    rate_d    = ta1p_d ? scap_pkg::fi_lookup(fi_d) : -13'sd1;
    fmax_d    = ta1p_d ? scap_pkg::f_lookup(fi_d) : -9'sd1;
    baud_d    = ta1p_d ? scap_pkg::di_lookup(di_d) : -7'sd1;
    guard_d   = (ok && tc1_here_d) ? $signed({1'b0, tc1_d}) : -9'sd1;
    remaining = pos_d - hstart_d;
    hcnt_d    = 4'd0;
    hoff_d    = 6'd0;
    if (ok && phase_d == PhTail && pos_d > hstart_d) begin
      hcnt_d = ({2'b00, decl_d} < remaining) ? decl_d : remaining[3:0];
      hoff_d = hstart_d;
    end
  end

  // Hold parser state; return to reset after the final transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhSync;
      mask_q     <= 4'd0;
      first_q    <= 1'b1;
      pos_q      <= 6'd0;
      decl_q     <= 4'd0;
      ta1_here_q <= 1'b0;
      ta1_q      <= 8'd0;
      tc1_here_q <= 1'b0;
      tc1_q      <= 8'd0;
      err_q      <= scap_pkg::ErrNone;
      hstart_q   <= 6'd0;
    end else if (take && last_byte_i) begin
      phase_q    <= PhSync;
      mask_q     <= 4'd0;
      first_q    <= 1'b1;
      pos_q      <= 6'd0;
      decl_q     <= 4'd0;
      ta1_here_q <= 1'b0;
      ta1_q      <= 8'd0;
      tc1_here_q <= 1'b0;
      tc1_q      <= 8'd0;
      err_q      <= scap_pkg::ErrNone;
      hstart_q   <= 6'd0;
    end else begin
      phase_q    <= phase_d;
      mask_q     <= mask_d;
      first_q    <= first_d;
      pos_q      <= pos_d;
      decl_q     <= decl_d;
      ta1_here_q <= ta1_here_d;
      ta1_q      <= ta1_d;
      tc1_here_q <= tc1_here_d;
      tc1_q      <= tc1_d;
      err_q      <= err_d;
      hstart_q   <= hstart_d;
    end
  end

  // Track result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take && last_byte_i) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load the result payload on the final transaction
  always_ff @(posedge clk_i) begin
    if (take && last_byte_i) begin
      status_q <= status_d;
      ta1p_q   <= ta1p_d;
      fi_q     <= fi_d;
      di_q     <= di_d;
      rate_q   <= rate_d;
      fmax_q   <= fmax_d;
      baud_q   <= baud_d;
      guard_q  <= guard_d;
      hcnt_q   <= hcnt_d;
      hoff_q   <= hoff_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign ta1_present_o  = ta1p_q;
  assign fi_index_o     = fi_q;
  assign di_index_o     = di_q;
  assign rate_factor_o  = rate_q;
  assign max_clock_o    = fmax_q;
  assign baud_divisor_o = baud_q;
  assign extra_guard_o  = guard_q;
  assign hist_count_o   = hcnt_q;
  assign hist_offset_o  = hoff_q;

endmodule

`default_nettype wire

// ----- rtl/scap_checker.sv -----
// Port-level checker for the ATR parser and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "smart_card_atr_parser_macros.svh"

module scap_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic [7:0]         atr_byte_i,
  input wire logic               byte_present_i,
  input wire logic               last_byte_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic [1:0]         status_o,
  input wire logic               ta1_present_o,
  input wire logic [3:0]         fi_index_o,
  input wire logic [3:0]         di_index_o,
  input wire logic signed [12:0] rate_factor_o,
  input wire logic signed [8:0]  max_clock_o,
  input wire logic signed [6:0]  baud_divisor_o,
  input wire logic signed [8:0]  extra_guard_o,
  input wire logic [3:0]         hist_count_o,
  input wire logic [5:0]         hist_offset_o
);

  // A final transaction always yields a result in the next cycle
  `SCAP_ASSERT_NEXT(a_last_gives_result, in_valid_i && !in_stall_o && last_byte_i, out_valid_o)

  // A stalled result holds its status, guard time and historical byte fields
  `SCAP_ASSERT_NEXT(a_result_holds, out_valid_o && out_stall_i, out_valid_o && $stable(status_o) && $stable(hist_count_o) && $stable(hist_offset_o) && $stable(extra_guard_o))

  // A failed ATR reports TA1, the guard time and the historical bytes as absent
  `SCAP_ASSERT_NOW(a_fail_absent, out_valid_o && status_o != scap_pkg::StatusOk, !ta1_present_o && extra_guard_o == -9'sd1 && hist_count_o == 4'd0 && hist_offset_o == 6'd0)

  // Missing TA1 leaves codes at zero and table values at -1
  `SCAP_ASSERT_NOW(a_no_ta1, out_valid_o && !ta1_present_o, fi_index_o == 4'd0 && di_index_o == 4'd0 && rate_factor_o == -13'sd1 && max_clock_o == -9'sd1 && baud_divisor_o == -7'sd1)

  // No historical bytes are reported without an offset
  `SCAP_ASSERT_NOW(a_hist_needs_offset, out_valid_o && hist_offset_o == 6'd0, hist_count_o == 4'd0)

endmodule

bind smart_card_atr_parser scap_checker u_scap_checker (.*);

`default_nettype wire

// ----- sim/atr_summary_checker.sv -----
// Checker that predicts the summary of each answer-to-reset and compares the parser results.
`timescale 1ns / 1ps

module atr_summary_checker #(
  parameter int unsigned MaxBytes = scap_pkg::MaxAtrBytesDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input channel, watched
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [7:0]         atr_byte_i,
  input  logic               byte_present_i,
  input  logic               last_byte_i,
  // result channel, watched
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [1:0]         status_i,
  input  logic               ta1_present_i,
  input  logic [3:0]         fi_index_i,
  input  logic [3:0]         di_index_i,
  input  logic signed [12:0] rate_factor_i,
  input  logic signed [8:0]  max_clock_i,
  input  logic signed [6:0]  baud_divisor_i,
  input  logic signed [8:0]  extra_guard_i,
  input  logic [3:0]         hist_count_i,
  input  logic [5:0]         hist_offset_i,
  // verdict inputs for the top
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef enum logic [1:0] {WaitSync, WaitT0, WalkGroups, HistBytes} parse_phase_e;

  typedef struct packed {
    logic [1:0]  status;
    logic        ta1_present;
    logic [3:0]  fi_index;
    logic [3:0]  di_index;
    logic [12:0] rate_factor;
    logic [8:0]  max_clock;
    logic [6:0]  baud_divisor;
    logic [8:0]  extra_guard;
    logic [3:0]  hist_count;
    logic [5:0]  hist_offset;
  } atr_summary_t;

  // TA1 tables, indexed by the Fi or Di nibble; -1 marks a reserved code
  localparam logic signed [12:0] RateTable [16] = '{
    13'sd372, 13'sd372, 13'sd558, 13'sd744, 13'sd1116, 13'sd1488, 13'sd1860, -13'sd1,
    -13'sd1, 13'sd512, 13'sd768, 13'sd1024, 13'sd1536, 13'sd2048, -13'sd1, -13'sd1};
  localparam logic signed [8:0] ClockTable [16] = '{
    9'sd40, 9'sd50, 9'sd60, 9'sd80, 9'sd120, 9'sd160, 9'sd200, -9'sd1,
    -9'sd1, 9'sd50, 9'sd75, 9'sd100, 9'sd150, 9'sd200, -9'sd1, -9'sd1};
  localparam logic signed [6:0] DivisorTable [16] = '{
    -7'sd1, 7'sd1, 7'sd2, 7'sd4, 7'sd8, 7'sd16, 7'sd32, -7'sd1,
    7'sd12, 7'sd20, -7'sd1, -7'sd1, -7'sd1, -7'sd1, -7'sd1, -7'sd1};

  // Parse state of the ATR in flight
  parse_phase_e phase;
  logic [3:0]   group_mask;
  logic         first_group;
  int           byte_count;
  logic [3:0]   declared_hist;
  logic         ta1_seen;
  logic [7:0]   ta1_code;
  logic         tc1_seen;
  logic [7:0]   tc1_code;
  logic [1:0]   sync_error;
  int           iface_end;

  atr_summary_t summary_q[$];
  int           mismatches = 0;
  int           queued = 0;
  int           results_seen = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = queued;

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  task automatic check_field(input string fname, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("result %0d field %s got %0d, want %0d",
                                results_seen, fname, got, want));
    end
  endtask

  task automatic clear_parse();
    phase         = WaitSync;
    group_mask    = 4'd0;
    first_group   = 1'b1;
    byte_count    = 0;
    declared_hist = 4'd0;
    ta1_seen      = 1'b0;
    ta1_code      = 8'd0;
    tc1_seen      = 1'b0;
    tc1_code      = 8'd0;
    sync_error    = scap_pkg::ErrNone;
    iface_end     = 0;
  endtask

  // Advance the parse by one byte of an ATR whose sync byte has not failed
  task automatic parse_byte(input logic [7:0] b);
    int slot;
    slot = 0;
    case (phase)
      WaitSync: begin
        if (b != scap_pkg::SyncDirect && b != scap_pkg::SyncInverse) begin
          sync_error = scap_pkg::ErrBadSync;
        end
        phase = WaitT0;
      end
      WaitT0: begin
        declared_hist = b[3:0];
        group_mask    = b[7:4];
        first_group   = 1'b1;
        if (group_mask == 4'd0) begin
          phase     = HistBytes;
          iface_end = byte_count + 1;
        end else begin
          phase = WalkGroups;
        end
      end
      WalkGroups: begin
        // lowest pending of TA, TB, TC; TD otherwise
        while (slot < 3 && !group_mask[slot[1:0]]) slot++;
        group_mask[slot[1:0]] = 1'b0;
        if (first_group && slot == 0) begin
          ta1_seen = 1'b1;
          ta1_code = b;
        end
        if (first_group && slot == 2) begin
          tc1_seen = 1'b1;
          tc1_code = b;
        end
        if (slot == 3) begin
          group_mask  = b[7:4];
          first_group = 1'b0;
        end
        if (group_mask == 4'd0) begin
          phase     = HistBytes;
          iface_end = byte_count + 1;
        end
      end
      default: ;
    endcase
  endtask

  // Absorb one accepted transaction; on the final one queue the summary
  task automatic take_item(input logic [7:0] b, input logic present, input logic last);
    atr_summary_t summary;
    logic         ok;
    int           remaining;
    if (present && byte_count < MaxBytes) begin
      if (sync_error == scap_pkg::ErrNone) parse_byte(b);
      byte_count++;
    end
    if (last) begin
      summary              = '0;
      summary.rate_factor  = '1;
      summary.max_clock    = '1;
      summary.baud_divisor = '1;
      summary.extra_guard  = '1;
      if (byte_count == 0) summary.status = scap_pkg::StatusEmpty;
      else if (sync_error != scap_pkg::ErrNone) summary.status = scap_pkg::StatusBadSync;
      else summary.status = scap_pkg::StatusOk;
      ok = (summary.status == scap_pkg::StatusOk);
      if (ok && ta1_seen) begin
        summary.ta1_present  = 1'b1;
        summary.fi_index     = ta1_code[7:4];
        summary.di_index     = ta1_code[3:0];
        summary.rate_factor  = RateTable[ta1_code[7:4]];
        summary.max_clock    = ClockTable[ta1_code[7:4]];
        summary.baud_divisor = DivisorTable[ta1_code[3:0]];
      end
      if (ok && tc1_seen) summary.extra_guard = {1'b0, tc1_code};
      // historical bytes only count when some arrived after the interface bytes
      if (ok && phase == HistBytes && byte_count > iface_end) begin
        remaining = byte_count - iface_end;
        if (int'(declared_hist) < remaining) summary.hist_count = declared_hist;
        else summary.hist_count = remaining[3:0];
        summary.hist_offset = iface_end[5:0];
      end
      summary_q.push_back(summary);
      clear_parse();
    end
  endtask

  // Compare one accepted result with the oldest queued summary
  task automatic check_result();
    atr_summary_t summary;
    results_seen++;
    if (summary_q.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with no ATR finished", results_seen));
    end else begin
      summary = summary_q.pop_front();
      check_field("status", int'(status_i), int'(summary.status));
      check_field("ta1_present", int'(ta1_present_i), int'(summary.ta1_present));
      check_field("fi_index", int'(fi_index_i), int'(summary.fi_index));
      check_field("di_index", int'(di_index_i), int'(summary.di_index));
      check_field("rate_factor", int'(rate_factor_i), int'($signed(summary.rate_factor)));
      check_field("max_clock", int'(max_clock_i), int'($signed(summary.max_clock)));
      check_field("baud_divisor", int'(baud_divisor_i),
                  int'($signed(summary.baud_divisor)));
      check_field("extra_guard", int'(extra_guard_i), int'($signed(summary.extra_guard)));
      check_field("hist_count", int'(hist_count_i), int'(summary.hist_count));
      check_field("hist_offset", int'(hist_offset_i), int'(summary.hist_offset));
    end
  endtask

  // Watch both channels; results leave before new bytes are absorbed
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parse();
      summary_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_i) take_item(atr_byte_i, byte_present_i, last_byte_i);
    end
    queued = summary_q.size();
  end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top: feeds ATR byte streams to the parser, paces both channels, gives the verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam int QuietLimit    = 3000;
  localparam int HoldOffCycles = 400;
  localparam int PhaseItems    = 160;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        atr_byte = 8'd0;
  logic              byte_present = 1'b0;
  logic              last_byte = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        status;
  logic              ta1_present;
  logic [3:0]        fi_index;
  logic [3:0]        di_index;
  logic signed [12:0] rate_factor;
  logic signed [8:0] max_clock;
  logic signed [6:0] baud_divisor;
  logic signed [8:0] extra_guard;
  logic [3:0]        hist_count;
  logic [5:0]        hist_offset;
  int                fail_count;
  int                pending;

  int                send_idle_pct = 0;
  int                stall_pct = 0;
  logic              hold_off = 1'b0;
  logic              pressure_go = 1'b0;
  int                items_sent = 0;
  int                quiet_cycles = 0;
  logic [7:0]        atr_bytes[$];
  logic              tail_without_byte = 1'b0;

  smart_card_atr_parser u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .atr_byte_i     (atr_byte),
    .byte_present_i (byte_present),
    .last_byte_i    (last_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .ta1_present_o  (ta1_present),
    .fi_index_o     (fi_index),
    .di_index_o     (di_index),
    .rate_factor_o  (rate_factor),
    .max_clock_o    (max_clock),
    .baud_divisor_o (baud_divisor),
    .extra_guard_o  (extra_guard),
    .hist_count_o   (hist_count),
    .hist_offset_o  (hist_offset)
  );

  atr_summary_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .atr_byte_i     (atr_byte),
    .byte_present_i (byte_present),
    .last_byte_i    (last_byte),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .status_i       (status),
    .ta1_present_i  (ta1_present),
    .fi_index_i     (fi_index),
    .di_index_i     (di_index),
    .rate_factor_i  (rate_factor),
    .max_clock_i    (max_clock),
    .baud_divisor_i (baud_divisor),
    .extra_guard_i  (extra_guard),
    .hist_count_i   (hist_count),
    .hist_offset_i  (hist_offset),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result side: stall at random, or hold off entirely during the pressure window
  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < stall_pct);
  end

  // Hold the result side off long enough for the parser to back up
  initial begin
    wait (pressure_go);
    hold_off = 1'b1;
    repeat (HoldOffCycles) @(posedge clk);
    hold_off = 1'b0;
  end

  // Drop the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Offer one transaction; entered and left at a falling edge
  task automatic send_item(input logic [7:0] b, input logic present, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    atr_byte     <= b;
    byte_present <= present;
    last_byte    <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (present || last) items_sent++;
  endtask

  // Send atr_bytes as one ATR, with stray empty transactions mixed in
  task automatic send_atr();
    for (int i = 0; i < atr_bytes.size(); i++) begin
      if ($urandom_range(99) < 3) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      send_item(atr_bytes[i], 1'b1, !tail_without_byte && i == atr_bytes.size() - 1);
    end
    if (tail_without_byte) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  // Build a mostly well-formed ATR with random content into atr_bytes
  task automatic build_atr(input int serial);
    logic [3:0] mask;
    logic [3:0] next;
    logic [3:0] hist;
    int         depth;
    int         keep;
    atr_bytes.delete();
    depth = 0;
    tail_without_byte = ($urandom_range(99) < 20);
    if ($urandom_range(99) < 4) begin
      tail_without_byte = 1'b1;
    end else begin
      if ($urandom_range(99) < 85) begin
        atr_bytes.push_back($urandom_range(1) ? scap_pkg::SyncDirect : scap_pkg::SyncInverse);
      end else begin
        atr_bytes.push_back(8'($urandom_range(255)));
      end
      mask = 4'($urandom_range(15));
      hist = 4'($urandom_range(15));
      atr_bytes.push_back({mask, hist});
      // walk the interface groups, chaining through TD
      while (mask != 4'd0) begin
        for (int s = 0; s < 3; s++) begin
          if (mask[s[1:0]]) atr_bytes.push_back(8'($urandom_range(255)));
        end
        next = 4'd0;
        if (mask[3]) begin
          if (depth < 3 && $urandom_range(1) == 1) next = 4'($urandom_range(15));
          atr_bytes.push_back({next, 4'($urandom_range(15))});
          depth++;
        end
        mask = next;
      end
      repeat (hist) atr_bytes.push_back(8'($urandom_range(255)));
      if ($urandom_range(99) < 25) atr_bytes.push_back(8'($urandom_range(255)));
      // cut some short, stretch a few past the length limit
      if ($urandom_range(99) < 15) begin
        keep = $urandom_range(atr_bytes.size(), 1);
        while (atr_bytes.size() > keep) void'(atr_bytes.pop_back());
      end
      if (serial % 29 == 7) begin
        while (atr_bytes.size() < 40) atr_bytes.push_back(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    int serial;
    serial = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty ATR
    atr_bytes.delete();
    tail_without_byte = 1'b1;
    send_atr();
    // stray empty transaction, then the shortest ATR
    send_item(8'h5A, 1'b0, 1'b0);
    atr_bytes = {scap_pkg::SyncDirect, 8'h00};
    tail_without_byte = 1'b0;
    send_atr();
    // bad sync byte
    atr_bytes = {8'hFF, 8'h11, 8'h22};
    send_atr();
    // all first groups present, reserved TA1 codes, largest guard time
    atr_bytes = {scap_pkg::SyncInverse, 8'hF1, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h41};
    send_atr();
    // truncated inside the interface bytes
    atr_bytes = {scap_pkg::SyncDirect, 8'h70, 8'h11};
    send_atr();
    // declared historical bytes that never arrive, ended by an empty final transaction
    atr_bytes = {scap_pkg::SyncDirect, 8'h1F, 8'h00};
    tail_without_byte = 1'b1;
    send_atr();
    // TD chain into a later TA, nothing left after it
    atr_bytes = {scap_pkg::SyncDirect, 8'h90, 8'h96, 8'h80, 8'h10, 8'h13};
    tail_without_byte = 1'b0;
    send_atr();

    // random ATRs through the pacing phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
          pressure_go   = 1'b1;
        end
        1: begin
          send_idle_pct = 67;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 67;
        end
        default: begin
          send_idle_pct = 20;
          stall_pct     = 20;
        end
      endcase
      while (items_sent < 30 + (ph + 1) * PhaseItems) begin
        build_atr(serial);
        send_atr();
        serial++;
      end
    end

    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/scap_pkg.sv
rtl/smart_card_atr_parser.sv
rtl/scap_checker.sv
sim/atr_summary_checker.sv
sim/tb_top.sv
